// ===== hw/rtl/u2a_pkg.sv =====
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int unsigned NUM_CELLS  = 16;
  localparam int unsigned CELL_IDX_W = 4;
  localparam int unsigned LEN_W      = 5;

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_LOWER_X = 7'h78;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;

  typedef enum logic [1:0] {
    MODE_DEC    = 2'd0,
    MODE_HEX_LO = 2'd1,
    MODE_HEX_UP = 2'd2,
    MODE_PTR    = 2'd3
  } mode_e;

  // Control shared by every digit cell in the row
  typedef struct packed {
    logic clr;
    logic shift;
    logic dec;
  } cell_ctrl_t;

  // One digit (0..15) to its ASCII code
  function automatic logic [6:0] ascii_digit(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      return CHAR_ZERO + {3'b000, d};
    end else begin
      return base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/u2a_cell.sv =====
`timescale 1ns / 1ps

// One digit of the conversion row: BCD add-3 correction in decimal,
// plain nibble shift in hex.
module u2a_cell (
  input  logic                clk_i,
  input  u2a_pkg::cell_ctrl_t ctrl_i,
  input  logic                bit_i,
  output logic                bit_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q;
  logic [3:0] adj;

  always_comb begin
    adj = digit_q;
    if (ctrl_i.dec && (digit_q >= 4'd5)) begin
      adj = digit_q + 4'd3;
    end
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      digit_q <= 4'd0;
    end else if (ctrl_i.shift) begin
      digit_q <= {adj[2:0], bit_i};
    end
  end

endmodule

// ===== hw/rtl/unsigned_to_ascii_digits.sv =====
`timescale 1ns / 1ps

// Unsigned number to ASCII digit string. One value and a mode are taken per
// input transfer; the block then delivers one output transfer per character,
// most significant first, no leading zeros, with last_o on the final one and
// char_count_o (1..18, "0x" prefix included) on every one. Mode 0 is decimal
// of value_i[31:0], modes 1/2 are lower/upper hex of value_i[31:0], mode 3 is
// "0x" plus lower hex of all 64 bits. Items are handled one at a time: the
// value is shifted one bit per cycle through a row of 16 digit cells (double
// dabble in decimal, plain nibble shift in hex), all 32 bits in modes 0-2 and
// all 64 in mode 3; a sizing state then counts the digits, the characters
// go out one per cycle while the output is not stalled, and the block returns
// to idle. The final character may still wait in the output register while
// the next item is taken.
module unsigned_to_ascii_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [1:0]  mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  character_o,
  output logic        last_o,
  output logic [4:0]  char_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_EMIT
  } state_e;

  localparam int unsigned NC = u2a_pkg::NUM_CELLS;
  localparam int unsigned LW = u2a_pkg::LEN_W;

  state_e      state_q;
  logic [63:0] val_q;
  logic [5:0]  cnt_q;
  logic        dec_q, upper_q, ptr_q;
  logic [LW-1:0] len_q, pos_q;
  logic        out_valid_q, last_q;
  logic [6:0]  char_q;
  logic [LW-1:0] count_q;

  logic        in_xfer;
  logic        slot_free;
  u2a_pkg::cell_ctrl_t ctrl;
  logic [3:0]  digit [NC];
  logic        carry [NC+1];

  assign in_xfer   = (state_q == S_IDLE) && in_valid_i;
  assign slot_free = !out_valid_q || !out_stall_i;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q;
  assign char_count_o = count_q;

  // Cell row: cell 0 is the least significant digit, fed from the top of val_q
  assign ctrl.clr   = in_xfer;
  assign ctrl.shift = (state_q == S_CONV);
  assign ctrl.dec   = dec_q;
  assign carry[0]   = val_q[63];

  for (genvar i = 0; i < NC; i++) begin : g_cell
    u2a_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (carry[i]),
      .bit_o   (carry[i+1]),
      .digit_o (digit[i])
    );
  end

  // Significant digit count, at least one
  logic [LW-1:0] nd;
  logic [LW-1:0] len_d;
  always_comb begin
    nd = LW'(1);
    for (int i = 1; i < NC; i++) begin
      if (digit[i] != 4'd0) begin
        nd = LW'(i + 1);
      end
    end
    len_d = nd + (ptr_q ? LW'(2) : LW'(0));
  end

  // Character at the current position
  logic [LW-1:0] rem;
  logic [u2a_pkg::CELL_IDX_W-1:0] dig_idx;
  logic [6:0]    char_d;
  logic          last_d;
  always_comb begin
    rem     = len_q - LW'(1) - pos_q;
    dig_idx = rem[u2a_pkg::CELL_IDX_W-1:0];
    last_d  = (rem == LW'(0));
    if (ptr_q && (pos_q == LW'(0))) begin
      char_d = u2a_pkg::CHAR_ZERO;
    end else if (ptr_q && (pos_q == LW'(1))) begin
      char_d = u2a_pkg::CHAR_LOWER_X;
    end else begin
      char_d = u2a_pkg::ascii_digit(digit[dig_idx], upper_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      val_q       <= '0;
      cnt_q       <= '0;
      dec_q       <= 1'b0;
      upper_q     <= 1'b0;
      ptr_q       <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      char_q      <= '0;
      count_q     <= '0;
    end else begin
      // output register drains outside the emit state; emit refills it itself
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dec_q   <= (u2a_pkg::mode_e'(mode_i) == u2a_pkg::MODE_DEC);
            upper_q <= (u2a_pkg::mode_e'(mode_i) == u2a_pkg::MODE_HEX_UP);
            ptr_q   <= (u2a_pkg::mode_e'(mode_i) == u2a_pkg::MODE_PTR);
            if (u2a_pkg::mode_e'(mode_i) == u2a_pkg::MODE_PTR) begin
              val_q <= value_i;
              cnt_q <= 6'd63;
            end else begin
              // narrow modes: low word goes first, MSB leading
              val_q <= {value_i[31:0], 32'd0};
              cnt_q <= 6'd31;
            end
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          // bit leaving the top cell recirculates; it is never read
          val_q <= {val_q[62:0], carry[NC]};
          if (cnt_q == 6'd0) begin
            state_q <= S_SIZE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_SIZE: begin
          len_q   <= len_d;
          pos_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= char_d;
            last_q      <= last_d;
            count_q     <= len_q;
            pos_q       <= pos_q + LW'(1);
            if (last_d) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/u2a_checker.sv =====
`timescale 1ns / 1ps

module u2a_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [63:0] value_i,
  input logic [1:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  character_o,
  input logic        last_o,
  input logic [4:0]  char_count_o
);

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o)
      && $stable(last_o) && $stable(char_count_o))
    else $error("stalled output changed");

  // Accepted item keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // Only the final character of a run may wait while the input is open
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> last_o)
    else $error("pending non-final character while idle");

  // Run length in range
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_count_o >= 5'd1) && (char_count_o <= 5'd18))
    else $error("character count out of range");

  // Run continues with the same count
  a_count_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o ##1 out_valid_o
      |-> char_count_o == $past(char_count_o))
    else $error("character count changed within a run");

endmodule

bind unsigned_to_ascii_digits u2a_checker u_u2a_checker (.*);

// ===== tb/unsigned_to_ascii_digits_test.sv =====
`timescale 1ns / 1ps

// Each input transfer (value, mode) is turned into its ASCII digit string here.
// The string is queued as one expected output transfer per character. Output
// transfers are checked in order against that queue.
module unsigned_to_ascii_digits_test;

  // Generous ceiling: ~120 items, each at most 18 characters long, with every
  // character facing a long receiver stall and every item a long sender gap.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 95;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    logic [63:0]     value;
    u2a_pkg::mode_e  mode;
  } number_t;

  typedef struct {
    logic [6:0] character;
    logic       last;
    logic [4:0] char_count;
  } glyph_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_i;
  logic [1:0]  mode_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [6:0]  character_o;
  logic        last_o;
  logic [4:0]  char_count_o;

  number_t     numbers_to_send[$];
  glyph_t      expected_glyphs[$];
  logic        in_taken = 1'b0;   // input transfer at the last rising edge
  logic        hold_off = 1'b0;   // long receiver hold-off in progress
  int unsigned cycle_cnt = 0;
  int unsigned numbers_taken = 0;
  int unsigned fail_cnt = 0;
  int unsigned send_wait = 0;
  int unsigned stall_wait = 0;

  unsigned_to_ascii_digits dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .mode_i       (mode_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o),
    .char_count_o (char_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Stretches with no idling on either side, one in every four.
  function automatic logic calm();
    return (cycle_cnt % 600) < 150;
  endfunction

  // Digit string of one number, most significant first, no leading zeros.
  // Narrow modes see only the low 32 bits; the pointer mode gets "0x".
  function automatic void predict_digits(input logic [63:0] value,
                                         input u2a_pkg::mode_e mode);
    string      lower_set;
    string      upper_set;
    string      prefix;
    logic [63:0] rest;
    logic [3:0]  digit;
    logic [6:0]  text[$];
    glyph_t      g;
    lower_set = "0123456789abcdef";
    upper_set = "0123456789ABCDEF";
    prefix    = "0x";
    rest      = (mode == u2a_pkg::MODE_PTR) ? value : {32'h0, value[31:0]};
    do begin
      if (mode == u2a_pkg::MODE_DEC) begin
        digit = 4'(rest % 64'd10);
        rest  = rest / 64'd10;
      end else begin
        digit = rest[3:0];
        rest  = rest >> 4;
      end
      if (mode == u2a_pkg::MODE_HEX_UP) begin
        text.push_front(7'(upper_set[digit]));
      end else begin
        text.push_front(7'(lower_set[digit]));
      end
    end while (rest != 64'd0);
    if (mode == u2a_pkg::MODE_PTR) begin
      text.push_front(7'(prefix[1]));
      text.push_front(7'(prefix[0]));
    end
    foreach (text[k]) begin
      g.character  = text[k];
      g.last       = (k == text.size() - 1);
      g.char_count = 5'(text.size());
      expected_glyphs.push_back(g);
    end
  endfunction

  // Sender: a new number goes up only once the previous one has been taken,
  // so a stalled transfer keeps its payload.
  always @(negedge clk_i) begin : sender
    number_t n;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_wait > 0) begin
          in_valid_i <= 1'b0;
          send_wait = send_wait - 1;
        end else if (numbers_to_send.size() != 0) begin
          n = numbers_to_send.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= n.value;
          mode_i     <= n.mode;
          send_wait = calm() ? 0 : gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random gaps, or solid during the hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_wait > 0) begin
        out_stall_i <= 1'b1;
        stall_wait = stall_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_wait = calm() ? 0 : gap_len();
      end
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk_i) begin : monitor
    glyph_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_digits(value_i, u2a_pkg::mode_e'(mode_i));
        numbers_taken = numbers_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected output transfer, character %h last %b count %0d",
                   $time, character_o, last_o, char_count_o);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = expected_glyphs.pop_front();
          if (character_o !== want.character) begin
            $display("%0t: character expected %h actual %h",
                     $time, want.character, character_o);
            fail_cnt = fail_cnt + 1;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last_o);
            fail_cnt = fail_cnt + 1;
          end
          if (char_count_o !== want.char_count) begin
            $display("%0t: char_count expected %0d actual %0d",
                     $time, want.char_count, char_count_o);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("unsigned_to_ascii_digits_test failed");
      $finish;
    end
  end

  // Long hold-off once traffic is flowing: the sender keeps offering, so the
  // block backs up and has to stall its input.
  initial begin
    wait (numbers_taken >= 40);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    logic [63:0] edge_values[5];
    logic [63:0] mask;
    number_t     n;
    int unsigned bits;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = 64'd0;
    mode_i      = u2a_pkg::MODE_DEC;
    out_stall_i = 1'b0;

    // Directed part: zero, one, the 32-bit maximum, upper bits that narrow
    // modes must ignore, and every hex letter, in each mode.
    edge_values[0] = 64'd0;
    edge_values[1] = 64'd1;
    edge_values[2] = 64'h0000_0000_FFFF_FFFF;
    edge_values[3] = 64'hFFFF_FFFF_0000_0000;
    edge_values[4] = 64'h0123_4567_89AB_CDEF;
    for (int m = 0; m < 4; m++) begin
      foreach (edge_values[i]) begin
        n.value = edge_values[i];
        n.mode  = u2a_pkg::mode_e'(m);
        numbers_to_send.push_back(n);
      end
    end
    // Decimal carries into a new digit; pointer at full width and top bit only.
    n.mode = u2a_pkg::MODE_DEC;
    n.value = 64'd9;          numbers_to_send.push_back(n);
    n.value = 64'd10;         numbers_to_send.push_back(n);
    n.value = 64'd1000000000; numbers_to_send.push_back(n);
    n.mode = u2a_pkg::MODE_PTR;
    n.value = 64'hFFFF_FFFF_FFFF_FFFF; numbers_to_send.push_back(n);
    n.value = 64'h8000_0000_0000_0000; numbers_to_send.push_back(n);

    // Random part: random bit length so that short and long strings both
    // turn up, with all 64 bits still toggling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      bits = $urandom_range(1, 64);
      mask = (bits == 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
      n.value = {$urandom, $urandom} & mask;
      n.mode  = u2a_pkg::mode_e'($urandom_range(0, 3));
      numbers_to_send.push_back(n);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Everything handed over, every character back, then a quiet tail.
    while (numbers_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("unsigned_to_ascii_digits_test passed");
    end else begin
      $display("unsigned_to_ascii_digits_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/u2a_pkg.sv
hw/rtl/u2a_cell.sv
hw/rtl/unsigned_to_ascii_digits.sv
hw/rtl/u2a_checker.sv
tb/unsigned_to_ascii_digits_test.sv
